/* rtl/anpc_pkg.sv */
`default_nettype none

package anpc_pkg;

  // One request: the instruction, its address, its operand registers and the flags.
  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] current_pc;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic [31:0] rs_value;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_carry;
    logic        flag_overflow;
  } anpc_req_t;

  typedef struct packed {
    logic [31:0] target_address;
    logic        from_memory;
    logic        condition_passed;
  } anpc_rsp_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_AND = 3'd1,
    ALU_EOR = 3'd2,
    ALU_ORR = 3'd3,
    ALU_MOV = 3'd4
  } anpc_alu_op_e;

  // Operands handed from the decode stage to the execute stage.
  typedef struct packed {
    anpc_alu_op_e op;
    logic [31:0]  opa;
    logic [31:0]  opb;
    logic         cin;
    logic         from_memory;
    logic         condition_passed;
    logic [31:0]  pc;
    logic [31:0]  pc_plus4;
  } anpc_exec_t;

  // Condition codes.
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_CS = 4'h2;
  localparam logic [3:0] COND_CC = 4'h3;
  localparam logic [3:0] COND_MI = 4'h4;
  localparam logic [3:0] COND_PL = 4'h5;
  localparam logic [3:0] COND_VS = 4'h6;
  localparam logic [3:0] COND_VC = 4'h7;
  localparam logic [3:0] COND_HI = 4'h8;
  localparam logic [3:0] COND_LS = 4'h9;
  localparam logic [3:0] COND_GE = 4'ha;
  localparam logic [3:0] COND_LT = 4'hb;
  localparam logic [3:0] COND_GT = 4'hc;
  localparam logic [3:0] COND_LE = 4'hd;

  // Instruction classes, bits 27:25.
  localparam logic [2:0] CLASS_DP_REG  = 3'd0;
  localparam logic [2:0] CLASS_DP_IMM  = 3'd1;
  localparam logic [2:0] CLASS_LDR_IMM = 3'd2;
  localparam logic [2:0] CLASS_LDR_REG = 3'd3;
  localparam logic [2:0] CLASS_LDM     = 3'd4;
  localparam logic [2:0] CLASS_BRANCH  = 3'd5;

  // Data-processing opcodes, bits 24:21.
  localparam logic [3:0] DP_AND = 4'h0;
  localparam logic [3:0] DP_EOR = 4'h1;
  localparam logic [3:0] DP_SUB = 4'h2;
  localparam logic [3:0] DP_RSB = 4'h3;
  localparam logic [3:0] DP_ADD = 4'h4;
  localparam logic [3:0] DP_ADC = 4'h5;
  localparam logic [3:0] DP_SBC = 4'h6;
  localparam logic [3:0] DP_RSC = 4'h7;
  localparam logic [3:0] DP_ORR = 4'hc;
  localparam logic [3:0] DP_MOV = 4'hd;
  localparam logic [3:0] DP_BIC = 4'he;
  localparam logic [3:0] DP_MVN = 4'hf;

  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  localparam logic [3:0]  REG_PC      = 4'hf;
  localparam logic [31:0] BX_MASK     = 32'h0fffffd0;
  localparam logic [31:0] BX_PATTERN  = 32'h012fff10;
  localparam logic [31:0] RD_PC_MASK  = 32'h0000f000;
  localparam logic [31:0] LDR_PC_MASK = 32'h0010f000;
  localparam logic [31:0] LDM_PC_MASK = 32'h00108000;

endpackage

`default_nettype wire

/* rtl/arm_next_pc_predictor_top.sv */
`default_nettype none

// Next-PC predictor for 32-bit ARM instructions. A request is taken at every clock edge
// where start_i is high; busy_o stays low, so one instruction can be issued in every cycle.
// Each result appears on rsp_o with done_o high for exactly one cycle, once the request has
// passed the input register, the execute register and the output register.
// The cycle after the request is spent on the condition check, operand read and barrel
// shift out of the input register; the next one on the ALU add and the self-jump check.
// Results come out in request order and cannot be held off, so the receiver must take them
// when shown. When rsp_o.from_memory is set, the next PC is the word stored at
// rsp_o.target_address.
module arm_next_pc_predictor_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  anpc_pkg::anpc_req_t  req_i,
  output logic                 done_o,
  output anpc_pkg::anpc_rsp_t  rsp_o
);

  logic                 req_accept;
  logic                 exec_valid;
  anpc_pkg::anpc_exec_t exec;

  assign busy_o     = 1'b0;
  assign req_accept = start_i && !busy_o;

  anpc_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_accept),
    .req_i        (req_i),
    .exec_valid_o (exec_valid),
    .exec_o       (exec)
  );

  anpc_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .exec_valid_i (exec_valid),
    .exec_i       (exec),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> ##3 done_o)
    else $error("request did not produce a result three cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_accept |-> ##3 !done_o)
    else $error("result strobe without a matching request");

endmodule

`default_nettype wire

/* rtl/anpc_decode.sv */
`default_nettype none

module anpc_decode (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   req_valid_i,
  input  anpc_pkg::anpc_req_t   req_i,
  output logic                  exec_valid_o,
  output anpc_pkg::anpc_exec_t  exec_o
);

  function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] t;
    t = {v, v} >> r;
    return t[31:0];
  endfunction

  function automatic logic [31:0] shift_imm(input logic [31:0] v, input logic [1:0] kind,
                                            input logic [4:0] amt, input logic c);
    logic [31:0] res;
    res = v;
    case (kind)
      anpc_pkg::SHIFT_LSL: res = v << amt;
      anpc_pkg::SHIFT_LSR: res = (amt == 5'd0) ? 32'd0 : (v >> amt);
      anpc_pkg::SHIFT_ASR: res = (amt == 5'd0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
      anpc_pkg::SHIFT_ROR: res = (amt == 5'd0) ? {c, v[31:1]} : rotr32(v, amt);
      default:             res = v;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] shift_reg(input logic [31:0] v, input logic [1:0] kind,
                                            input logic [7:0] amt);
    logic        big;
    logic [31:0] res;
    big = (amt[7:5] != 3'd0);
    res = v;
    case (kind)
      anpc_pkg::SHIFT_LSL: res = big ? 32'd0 : (v << amt[4:0]);
      anpc_pkg::SHIFT_LSR: res = big ? 32'd0 : (v >> amt[4:0]);
      anpc_pkg::SHIFT_ASR: res = big ? {32{v[31]}} : 32'($signed(v) >>> amt[4:0]);
      anpc_pkg::SHIFT_ROR: res = rotr32(v, amt[4:0]);
      default:             res = v;
    endcase
    return res;
  endfunction

  function automatic logic cond_pass(input logic [3:0] cond, input logic n, input logic z,
                                     input logic c, input logic v);
    logic res;
    case (cond)
      anpc_pkg::COND_EQ: res = z;
      anpc_pkg::COND_NE: res = !z;
      anpc_pkg::COND_CS: res = c;
      anpc_pkg::COND_CC: res = !c;
      anpc_pkg::COND_MI: res = n;
      anpc_pkg::COND_PL: res = !n;
      anpc_pkg::COND_VS: res = v;
      anpc_pkg::COND_VC: res = !v;
      anpc_pkg::COND_HI: res = c && !z;
      anpc_pkg::COND_LS: res = !c || z;
      anpc_pkg::COND_GE: res = (n == v);
      anpc_pkg::COND_LT: res = (n != v);
      anpc_pkg::COND_GT: res = !z && (n == v);
      anpc_pkg::COND_LE: res = z || (n != v);
      default:           res = 1'b1;
    endcase
    return res;
  endfunction

  logic                 in_valid_q;
  anpc_pkg::anpc_req_t  in_q;
  logic                 exec_valid_q;
  anpc_pkg::anpc_exec_t exec_q;
  anpc_pkg::anpc_exec_t exec_d;

  logic [31:0] ins;
  logic [31:0] pc;
  logic [31:0] pc8;
  logic [31:0] rn;
  logic [31:0] rm;
  logic [31:0] rs;
  logic        pass;
  logic [31:0] op2;
  logic [31:0] ldr_off;
  logic [31:0] ldm_off;
  logic [4:0]  reg_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      in_q <= req_i;
    end
  end

  assign ins = in_q.instruction;
  assign pc  = in_q.current_pc;
  assign pc8 = pc + 32'd8;
  // Register 15 reads as the address of the instruction plus eight.
  assign rn  = (ins[19:16] == anpc_pkg::REG_PC) ? pc8 : in_q.rn_value;
  assign rm  = (ins[3:0]   == anpc_pkg::REG_PC) ? pc8 : in_q.rm_value;
  assign rs  = (ins[11:8]  == anpc_pkg::REG_PC) ? pc8 : in_q.rs_value;
  assign pass = cond_pass(ins[31:28], in_q.flag_negative, in_q.flag_zero,
                          in_q.flag_carry, in_q.flag_overflow);

  always_comb begin
    if (ins[25]) begin
      op2 = rotr32({24'd0, ins[7:0]}, {ins[11:8], 1'b0});
    end else if (ins[4]) begin
      op2 = shift_reg(rm, ins[6:5], rs[7:0]);
    end else begin
      op2 = shift_imm(rm, ins[6:5], ins[11:7], in_q.flag_carry);
    end
  end

  assign ldr_off = ins[25] ? shift_imm(rm, ins[6:5], ins[11:7], in_q.flag_carry)
                           : {20'd0, ins[11:0]};

  // The list holds R15, so the count is at least one and the decrement never wraps.
  assign reg_count = 5'($countones(ins[15:0]));
  always_comb begin
    if (ins[23]) begin
      ldm_off = {25'd0, reg_count, 2'b00} - (ins[24] ? 32'd0 : 32'd4);
    end else begin
      ldm_off = ins[24] ? 32'hffff_fffc : 32'd0;
    end
  end

  always_comb begin
    exec_d.op               = anpc_pkg::ALU_ADD;
    exec_d.opa              = pc;
    exec_d.opb              = 32'd4;
    exec_d.cin              = 1'b0;
    exec_d.from_memory      = 1'b0;
    exec_d.condition_passed = pass;
    exec_d.pc               = pc;
    exec_d.pc_plus4         = pc + 32'd4;
    if (pass) begin
      case (ins[27:25])
        anpc_pkg::CLASS_DP_REG, anpc_pkg::CLASS_DP_IMM: begin
          if ((ins & anpc_pkg::RD_PC_MASK) == anpc_pkg::RD_PC_MASK) begin
            if ((ins & anpc_pkg::BX_MASK) == anpc_pkg::BX_PATTERN) begin
              exec_d.op  = anpc_pkg::ALU_MOV;
              exec_d.opb = rm;
            end else begin
              // Subtractions become additions of the inverted operand.
              case (ins[24:21])
                anpc_pkg::DP_AND: begin
                  exec_d.op  = anpc_pkg::ALU_AND;
                  exec_d.opa = rn;
                  exec_d.opb = op2;
                end
                anpc_pkg::DP_EOR: begin
                  exec_d.op  = anpc_pkg::ALU_EOR;
                  exec_d.opa = rn;
                  exec_d.opb = op2;
                end
                anpc_pkg::DP_SUB: begin
                  exec_d.opa = rn;
                  exec_d.opb = ~op2;
                  exec_d.cin = 1'b1;
                end
                anpc_pkg::DP_RSB: begin
                  exec_d.opa = op2;
                  exec_d.opb = ~rn;
                  exec_d.cin = 1'b1;
                end
                anpc_pkg::DP_ADD: begin
                  exec_d.opa = rn;
                  exec_d.opb = op2;
                end
                anpc_pkg::DP_ADC: begin
                  exec_d.opa = rn;
                  exec_d.opb = op2;
                  exec_d.cin = in_q.flag_carry;
                end
                anpc_pkg::DP_SBC: begin
                  exec_d.opa = rn;
                  exec_d.opb = ~op2;
                  exec_d.cin = in_q.flag_carry;
                end
                anpc_pkg::DP_RSC: begin
                  exec_d.opa = op2;
                  exec_d.opb = ~rn;
                  exec_d.cin = in_q.flag_carry;
                end
                anpc_pkg::DP_ORR: begin
                  exec_d.op  = anpc_pkg::ALU_ORR;
                  exec_d.opa = rn;
                  exec_d.opb = op2;
                end
                anpc_pkg::DP_MOV: begin
                  exec_d.op  = anpc_pkg::ALU_MOV;
                  exec_d.opb = op2;
                end
                anpc_pkg::DP_BIC: begin
                  exec_d.op  = anpc_pkg::ALU_AND;
                  exec_d.opa = rn;
                  exec_d.opb = ~op2;
                end
                anpc_pkg::DP_MVN: begin
                  exec_d.op  = anpc_pkg::ALU_MOV;
                  exec_d.opb = ~op2;
                end
                default: begin
                  // The compare and test ops write no register: fall through.
                  exec_d.op = anpc_pkg::ALU_ADD;
                end
              endcase
            end
          end
        end
        anpc_pkg::CLASS_LDR_IMM, anpc_pkg::CLASS_LDR_REG: begin
          if ((ins & anpc_pkg::LDR_PC_MASK) == anpc_pkg::LDR_PC_MASK) begin
            exec_d.from_memory = 1'b1;
            exec_d.opa         = rn;
            if (!ins[24]) begin
              exec_d.opb = 32'd0;
            end else if (ins[23]) begin
              exec_d.opb = ldr_off;
            end else begin
              exec_d.opb = ~ldr_off;
              exec_d.cin = 1'b1;
            end
          end
        end
        anpc_pkg::CLASS_LDM: begin
          if ((ins & anpc_pkg::LDM_PC_MASK) == anpc_pkg::LDM_PC_MASK) begin
            exec_d.from_memory = 1'b1;
            exec_d.opa         = rn;
            exec_d.opb         = ldm_off;
          end
        end
        anpc_pkg::CLASS_BRANCH: begin
          exec_d.opa = pc8;
          exec_d.opb = {{6{ins[23]}}, ins[23:0], 2'b00};
        end
        default: begin
          exec_d.op = anpc_pkg::ALU_ADD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
    end else begin
      exec_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      exec_q <= exec_d;
    end
  end

  assign exec_valid_o = exec_valid_q;
  assign exec_o       = exec_q;

endmodule

`default_nettype wire

/* rtl/anpc_exec.sv */
`default_nettype none

module anpc_exec (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   exec_valid_i,
  input  anpc_pkg::anpc_exec_t  exec_i,
  output logic                  done_o,
  output anpc_pkg::anpc_rsp_t   rsp_o
);

  logic [31:0]         sum;
  logic [31:0]         alu_res;
  anpc_pkg::anpc_rsp_t rsp_d;
  anpc_pkg::anpc_rsp_t rsp_q;
  logic                done_q;

  assign sum = exec_i.opa + exec_i.opb + {31'd0, exec_i.cin};

  always_comb begin
    case (exec_i.op)
      anpc_pkg::ALU_ADD: alu_res = sum;
      anpc_pkg::ALU_AND: alu_res = exec_i.opa & exec_i.opb;
      anpc_pkg::ALU_EOR: alu_res = exec_i.opa ^ exec_i.opb;
      anpc_pkg::ALU_ORR: alu_res = exec_i.opa | exec_i.opb;
      anpc_pkg::ALU_MOV: alu_res = exec_i.opb;
      default:           alu_res = sum;
    endcase
  end

  always_comb begin
    rsp_d.target_address   = alu_res;
    rsp_d.from_memory      = exec_i.from_memory;
    rsp_d.condition_passed = exec_i.condition_passed;
    // A computed jump to itself is reported as falling through.
    if (!exec_i.from_memory && (alu_res == exec_i.pc)) begin
      rsp_d.target_address = exec_i.pc_plus4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= exec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_mem_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && rsp_q.from_memory |-> rsp_q.condition_passed)
    else $error("load target reported for an instruction that failed its condition");

  a_fail_falls_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_valid_i && !exec_i.condition_passed |=> rsp_q.target_address == $past(exec_i.pc_plus4))
    else $error("failed condition did not give the next sequential address");

  a_no_self_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_valid_i && !exec_i.from_memory |=> rsp_q.target_address != $past(exec_i.pc))
    else $error("computed target equals the instruction address");

endmodule

`default_nettype wire
